### rtl/core/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants of the first-fit range allocator
// Status codes, reset values, controller/datapath command and status groups,
// and the alignment mask helper.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int POOL_DEPTH_DEF = 128;
    localparam int ADDR_BITS_DEF  = 47;
    localparam int ALIGN_BITS     = 31;
    localparam int MASK_BITS      = ALIGN_BITS - 1;

    localparam logic [63:0]           BUMP_RESET  = 64'h0000_0000_2000_0000;
    localparam logic [ALIGN_BITS-1:0] ALIGN_RESET = 31'd4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_FREE_IGNORED = 2'd1,
        STATUS_DROPPED      = 2'd2,
        STATUS_BUMP_RANGE   = 2'd3
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic check;
        logic scan;
        logic bump1;
        logic bump2;
        logic ahit;
        logic fmerge;
        logic fact;
        logic shift;
        logic ins;
        logic dec;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op_free;
        logic req_bad;
        logic scan_hit;
        logic scan_end;
        logic exact;
        logic trim;
        logic split_ins;
        logic pm;
        logic sm;
        logic full;
        logic mv_done;
    } dp_stat_t;

    // Mask of an alignment: highest set bit as a power of two, minus one
    function automatic logic [MASK_BITS-1:0] align_mask(input logic [ALIGN_BITS-1:0] a);
        logic [ALIGN_BITS-1:0] s;
        s = a;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        return s[ALIGN_BITS-1:1];
    endfunction

endpackage

### rtl/core/ffra_ram.sv
// ----------------------------------------------------------------------------
// ffra_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ffra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl: request sequencer of the range allocator
// Steps one request through check, table scan, update and entry shifting.
// ----------------------------------------------------------------------------
module ffra_ctrl
    import ffra_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_CHECK  = 11'b000_0000_0010,
        ST_SCAN   = 11'b000_0000_0100,
        ST_BUMP1  = 11'b000_0000_1000,
        ST_BUMP2  = 11'b000_0001_0000,
        ST_AHIT   = 11'b000_0010_0000,
        ST_FMERGE = 11'b000_0100_0000,
        ST_FACT   = 11'b000_1000_0000,
        ST_SHIFT  = 11'b001_0000_0000,
        ST_INS    = 11'b010_0000_0000,
        ST_DEC    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   ins_after_reg, ins_after_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        ins_after_next = ins_after_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.op_free && stat.req_bad)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_hit)
                begin
                    state_next = stat.op_free ? ST_FMERGE : ST_AHIT;
                end
                else if (stat.scan_end)
                begin
                    state_next = stat.op_free ? ST_FMERGE : ST_BUMP1;
                end
            end
            ST_BUMP1:
            begin
                cmd.bump1  = 1'b1;
                state_next = ST_BUMP2;
            end
            ST_BUMP2:
            begin
                cmd.bump2  = 1'b1;
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            ST_AHIT:
            begin
                cmd.ahit = 1'b1;
                if (stat.exact)
                begin
                    ins_after_next = 1'b0;
                    state_next     = ST_SHIFT;
                end
                else if (stat.split_ins)
                begin
                    ins_after_next = 1'b1;
                    state_next     = ST_SHIFT;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FMERGE:
            begin
                cmd.fmerge = 1'b1;
                state_next = ST_FACT;
            end
            ST_FACT:
            begin
                cmd.fact = 1'b1;
                if (stat.pm && stat.sm)
                begin
                    ins_after_next = 1'b0;
                    state_next     = ST_SHIFT;
                end
                else if (!stat.pm && !stat.sm && !stat.full)
                begin
                    ins_after_next = 1'b1;
                    state_next     = ST_SHIFT;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.mv_done)
                begin
                    state_next = ins_after_reg ? ST_INS : ST_DEC;
                end
            end
            ST_INS:
            begin
                cmd.ins    = 1'b1;
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DEC:
            begin
                cmd.dec    = 1'b1;
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ins_after_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ins_after_reg <= ins_after_next;
        end
    end

endmodule

### rtl/core/ffra_dp.sv
// ----------------------------------------------------------------------------
// ffra_dp: datapath of the range allocator
// Free table RAM, scan pipeline, entry mover, bump pointer and result beat.
// ----------------------------------------------------------------------------
module ffra_dp
    import ffra_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op,
    input  logic [ADDR_BITS-1:0]  range_addr,
    input  logic [ADDR_BITS-1:0]  range_size,
    input  logic [ALIGN_BITS-1:0] alignment,
    input  logic                  cfg_wr_en,
    input  logic [ALIGN_BITS-1:0] cfg_wr_data,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic                  done,
    output logic [ADDR_BITS-1:0]  result_addr,
    output logic                  from_bump,
    output logic [1:0]            status
);

    localparam int AW = ADDR_BITS;
    localparam int IW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int EW = 2 * AW;

    // Control state
    logic [ALIGN_BITS-1:0] cfg_align_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         bump_reg;
    logic [CW-1:0]         idx_reg;
    logic                  eval_vld_reg;
    logic                  done_reg;
    logic [IW-1:0]         mv_rd_reg;
    logic [CW-1:0]         mv_left_reg;
    logic                  mv_up_reg;
    logic                  mv_wpend_reg;
    logic [IW-1:0]         mv_waddr_reg;
    logic                  has_pred_reg;
    logic                  has_succ_reg;
    logic                  pm_reg;
    logic                  sm_reg;

    // Payload
    logic                 op_reg;
    logic [AW-1:0]        addr_reg;
    logic [AW-1:0]        size_reg;
    logic [MASK_BITS-1:0] mask_reg;
    logic [CW-1:0]        eval_idx_reg;
    logic [AW-1:0]        hit_st_reg;
    logic [AW-1:0]        hit_len_reg;
    logic [MASK_BITS-1:0] hit_waste_reg;
    logic [AW:0]          hit_need_reg;
    logic [IW-1:0]        hit_idx_reg;
    logic [CW-1:0]        pos_reg;
    logic [AW-1:0]        pred_st_reg;
    logic [AW-1:0]        pred_len_reg;
    logic [AW-1:0]        plsum_reg;
    logic [AW-1:0]        slsum_reg;
    logic [AW:0]          bal_reg;
    logic [IW-1:0]        ent_idx_reg;
    logic [AW-1:0]        ent_st_reg;
    logic [AW-1:0]        ent_len_reg;
    logic [AW-1:0]        res_addr_reg;
    logic                 res_bump_reg;
    status_t              res_status_reg;

    // RAM ports
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    // Combinational terms
    logic [AW-1:0]        ev_st;
    logic [AW-1:0]        ev_len;
    logic [MASK_BITS-1:0] ev_waste;
    logic [AW:0]          ev_need;
    logic                 ev_fit;
    logic                 ev_lt;
    logic                 scan_more;
    logic [AW:0]          req_sum;
    logic                 req_bad;
    logic                 full;
    logic                 waste_zero;
    logic                 exact;
    logic                 trim;
    logic [AW:0]          rest;
    logic                 rest_nz;
    logic                 split_ins;
    logic [AW:0]          as_sum;
    logic [AW:0]          tail_sum;
    logic [AW:0]          pred_end;
    logic [AW:0]          free_end;
    logic [AW:0]          mask_ext;
    logic [AW:0]          bal_next;
    logic [AW+1:0]        bsum;
    logic                 mv_load_down;
    logic                 mv_load_up;
    logic [CW-1:0]        mv_base;
    logic                 mv_done;

    ffra_ram #(
        .WIDTH (EW),
        .DEPTH (POOL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Evaluate the entry read in the previous cycle
    assign ev_st     = ram_rdata[EW-1:AW];
    assign ev_len    = ram_rdata[AW-1:0];
    assign ev_waste  = (MASK_BITS'(0) - ev_st[MASK_BITS-1:0]) & mask_reg;
    assign ev_need   = {{(AW+1-MASK_BITS){1'b0}}, ev_waste} + {1'b0, size_reg};
    assign ev_fit    = ({1'b0, ev_len} >= ev_need);
    assign ev_lt     = (ev_st < addr_reg);
    assign scan_more = (idx_reg < count_reg);

    // Free request check
    assign req_sum = {1'b0, addr_reg} + {1'b0, size_reg};
    assign req_bad = (addr_reg == '0) || (size_reg == '0)
                     || (req_sum[AW] && (req_sum[AW-1:0] != '0));

    // Allocation hit decisions
    assign full       = (count_reg == CW'(POOL_DEPTH));
    assign waste_zero = (hit_waste_reg == '0);
    assign exact      = waste_zero && (hit_len_reg == size_reg);
    assign trim       = waste_zero && !exact;
    assign rest       = {1'b0, hit_len_reg} - hit_need_reg;
    assign rest_nz    = (rest != '0);
    assign split_ins  = !waste_zero && rest_nz && !full;
    assign as_sum     = {1'b0, hit_st_reg} + {{(AW+1-MASK_BITS){1'b0}}, hit_waste_reg};
    assign tail_sum   = {1'b0, hit_st_reg} + hit_need_reg;

    // Free merge checks
    assign pred_end = {1'b0, pred_st_reg} + {1'b0, pred_len_reg};
    assign free_end = {1'b0, addr_reg} + {1'b0, size_reg};

    // Bump pointer alignment and advance
    assign mask_ext = {{(AW+1-MASK_BITS){1'b0}}, mask_reg};
    assign bal_next = ({1'b0, bump_reg} + mask_ext) & ~mask_ext;
    assign bsum     = {1'b0, bal_reg} + {2'b00, size_reg};

    // Mover setup
    assign mv_load_down = (cmd.ahit && exact) || (cmd.fact && pm_reg && sm_reg);
    assign mv_load_up   = (cmd.ahit && split_ins)
                          || (cmd.fact && !pm_reg && !sm_reg && !full);
    assign mv_base      = cmd.ahit ? (CW'(hit_idx_reg) + CW'(!exact)) : pos_reg;
    assign mv_done      = (mv_left_reg == '0) && !mv_wpend_reg;

    assign stat.op_free   = (op_reg == OP_FREE);
    assign stat.req_bad   = req_bad;
    assign stat.scan_hit  = eval_vld_reg && ((op_reg == OP_FREE) ? !ev_lt : ev_fit);
    assign stat.scan_end  = !scan_more && !eval_vld_reg;
    assign stat.exact     = exact;
    assign stat.trim      = trim;
    assign stat.split_ins = split_ins;
    assign stat.pm        = pm_reg;
    assign stat.sm        = sm_reg;
    assign stat.full      = full;
    assign stat.mv_done   = mv_done;

    // Read address: scan index or mover source
    assign ram_raddr = cmd.scan ? idx_reg[IW-1:0] : mv_rd_reg;

    // Write port select
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = mv_waddr_reg;
        ram_wdata = ram_rdata;
        priority if (cmd.shift && mv_wpend_reg)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.ahit && trim)
        begin
            ram_we    = 1'b1;
            ram_waddr = hit_idx_reg;
            ram_wdata = {hit_st_reg + size_reg, hit_len_reg - size_reg};
        end
        else if (cmd.ahit && !waste_zero)
        begin
            ram_we    = 1'b1;
            ram_waddr = hit_idx_reg;
            ram_wdata = {hit_st_reg, {(AW-MASK_BITS){1'b0}}, hit_waste_reg};
        end
        else if (cmd.fact && pm_reg && sm_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = IW'(pos_reg - CW'(1));
            ram_wdata = {pred_st_reg, plsum_reg + hit_len_reg};
        end
        else if (cmd.fact && sm_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = IW'(pos_reg);
            ram_wdata = {addr_reg, slsum_reg};
        end
        else if (cmd.fact && pm_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = IW'(pos_reg - CW'(1));
            ram_wdata = {pred_st_reg, plsum_reg};
        end
        else if (cmd.ins)
        begin
            ram_we    = 1'b1;
            ram_waddr = ent_idx_reg;
            ram_wdata = {ent_st_reg, ent_len_reg};
        end
    end

    // Entry count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_align_reg <= ALIGN_RESET;
            count_reg     <= '0;
            bump_reg      <= AW'(BUMP_RESET);
            idx_reg       <= '0;
            eval_vld_reg  <= 1'b0;
            done_reg      <= 1'b0;
            mv_rd_reg     <= '0;
            mv_left_reg   <= '0;
            mv_up_reg     <= 1'b0;
            mv_wpend_reg  <= 1'b0;
            mv_waddr_reg  <= '0;
            has_pred_reg  <= 1'b0;
            has_succ_reg  <= 1'b0;
            pm_reg        <= 1'b0;
            sm_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cfg_align_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            done_reg  <= cmd.finish;

            // Start a request
            if (cmd.load)
            begin
                idx_reg      <= '0;
                eval_vld_reg <= 1'b0;
                has_pred_reg <= 1'b0;
                has_succ_reg <= 1'b0;
            end

            // Advance the scan: one read issued per cycle
            if (cmd.scan)
            begin
                eval_vld_reg <= scan_more;
                if (scan_more)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
                if (eval_vld_reg && (op_reg == OP_FREE) && ev_lt)
                begin
                    has_pred_reg <= 1'b1;
                end
                if (stat.scan_hit)
                begin
                    has_succ_reg <= 1'b1;
                end
            end

            if (cmd.bump2)
            begin
                bump_reg <= bsum[AW-1:0];
            end

            // Merge flags for a free
            if (cmd.fmerge)
            begin
                pm_reg <= has_pred_reg && (pred_end == {1'b0, addr_reg});
                sm_reg <= has_succ_reg && (free_end == {1'b0, hit_st_reg});
            end

            // Load the mover or step it
            if (mv_load_down)
            begin
                mv_up_reg    <= 1'b0;
                mv_rd_reg    <= IW'(mv_base + CW'(1));
                mv_left_reg  <= count_reg - mv_base - CW'(1);
                mv_wpend_reg <= 1'b0;
            end
            else if (mv_load_up)
            begin
                mv_up_reg    <= 1'b1;
                mv_rd_reg    <= IW'(count_reg - CW'(1));
                mv_left_reg  <= count_reg - mv_base;
                mv_wpend_reg <= 1'b0;
            end
            else if (cmd.shift)
            begin
                mv_wpend_reg <= (mv_left_reg != '0);
                if (mv_left_reg != '0)
                begin
                    mv_left_reg  <= mv_left_reg - CW'(1);
                    mv_rd_reg    <= mv_up_reg ? mv_rd_reg - IW'(1) : mv_rd_reg + IW'(1);
                    mv_waddr_reg <= mv_up_reg ? mv_rd_reg + IW'(1) : mv_rd_reg - IW'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        // Capture the request and clear the result
        if (cmd.load)
        begin
            op_reg         <= op;
            addr_reg       <= range_addr;
            size_reg       <= range_size;
            mask_reg       <= align_mask((alignment != '0) ? alignment : cfg_align_reg);
            res_addr_reg   <= '0;
            res_bump_reg   <= 1'b0;
            res_status_reg <= STATUS_OK;
        end

        if (cmd.check && (op_reg == OP_FREE) && req_bad)
        begin
            res_status_reg <= STATUS_FREE_IGNORED;
        end

        // Scan bookkeeping
        if (cmd.scan)
        begin
            eval_idx_reg <= idx_reg;
            if (eval_vld_reg && (op_reg == OP_FREE) && ev_lt)
            begin
                pred_st_reg  <= ev_st;
                pred_len_reg <= ev_len;
            end
            if (stat.scan_hit)
            begin
                hit_st_reg    <= ev_st;
                hit_len_reg   <= ev_len;
                hit_waste_reg <= ev_waste;
                hit_need_reg  <= ev_need;
                hit_idx_reg   <= eval_idx_reg[IW-1:0];
                pos_reg       <= eval_idx_reg;
            end
            else if (stat.scan_end)
            begin
                pos_reg <= count_reg;
            end
        end

        // Allocation from a table entry
        if (cmd.ahit)
        begin
            res_addr_reg <= as_sum[AW-1:0];
            ent_idx_reg  <= hit_idx_reg + IW'(1);
            ent_st_reg   <= tail_sum[AW-1:0];
            ent_len_reg  <= rest[AW-1:0];
            if (!waste_zero && rest_nz && full)
            begin
                res_status_reg <= STATUS_DROPPED;
            end
        end

        // Allocation from the bump pointer
        if (cmd.bump1)
        begin
            bal_reg <= bal_next;
        end
        if (cmd.bump2)
        begin
            res_addr_reg <= bal_reg[AW-1:0];
            res_bump_reg <= 1'b1;
            if (bsum[AW+1:AW] != 2'b00)
            begin
                res_status_reg <= STATUS_BUMP_RANGE;
            end
        end

        if (cmd.fmerge)
        begin
            plsum_reg <= pred_len_reg + size_reg;
            slsum_reg <= hit_len_reg + size_reg;
        end

        // Free that merges with nothing
        if (cmd.fact)
        begin
            ent_idx_reg <= IW'(pos_reg);
            ent_st_reg  <= addr_reg;
            ent_len_reg <= size_reg;
            if (!pm_reg && !sm_reg && full)
            begin
                res_status_reg <= STATUS_DROPPED;
            end
        end
    end

    assign done        = done_reg;
    assign result_addr = res_addr_reg;
    assign from_bump   = res_bump_reg;
    assign status      = res_status_reg;

endmodule

### rtl/core/first_fit_range_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator_top: first-fit range allocator
//
//   Channel   Signals                                          Handshake
//   request   op, range_addr, range_size, alignment            start & !busy
//   result    result_addr, from_bump, status                   done (one cycle)
//   config    cfg_wr_data                                      cfg_wr_en
//
// A request keeps busy high while its work runs: S table entries read by the
// scan (one per cycle through the table RAM read port) and M entries moved on
// an insert or removal (one per cycle, read and write port). The scan stops
// where the move starts. The result beat follows in the cycle after the work
// ends, and a new request may start in that cycle. Reset is asynchronous and
// needs no clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_top
    import ffra_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  op,
    input  logic [ADDR_BITS-1:0]  range_addr,
    input  logic [ADDR_BITS-1:0]  range_size,
    input  logic [ALIGN_BITS-1:0] alignment,
    input  logic                  cfg_wr_en,
    input  logic [ALIGN_BITS-1:0] cfg_wr_data,
    output logic                  done,
    output logic [ADDR_BITS-1:0]  result_addr,
    output logic                  from_bump,
    output logic [1:0]            status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ffra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    ffra_dp #(
        .POOL_DEPTH (POOL_DEPTH),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .range_addr  (range_addr),
        .range_size  (range_size),
        .alignment   (alignment),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .done        (done),
        .result_addr (result_addr),
        .from_bump   (from_bump),
        .status      (status)
    );

endmodule

### verif/first_fit_range_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// first_fit_range_allocator_top_tb: self-checking bench of the range allocator
// Drives allocate and free requests through the command handshake, predicts
// every result with a local model of the free table and bump pointer, and
// compares each done beat field by field. Covers directed corner cases, then
// random traffic mixing allocations with frees of allocated ranges, under several
// default alignments.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_top_tb;
    import ffra_pkg::*;

    localparam int DEPTH    = 128;
    localparam int AW       = 47;
    localparam int WDOG_MAX = 20000;
    localparam logic [AW:0] ADDR_SPAN = 48'h8000_0000_0000;

    typedef struct packed {
        logic [AW-1:0] addr;
        logic          bump;
        status_t       st;
    } alloc_result_t;

    typedef struct {
        logic            op;
        logic [AW-1:0]   addr;
        logic [AW-1:0]   size;
        logic [30:0]     align;
        bit              known;
        alloc_result_t   res;
    } request_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  op;
    logic [AW-1:0]         range_addr;
    logic [AW-1:0]         range_size;
    logic [30:0]           alignment;
    logic                  cfg_wr_en;
    logic [30:0]           cfg_wr_data;
    logic                  done;
    logic [AW-1:0]         result_addr;
    logic                  from_bump;
    logic [1:0]            status;

    // model state
    logic [AW-1:0]   free_start [DEPTH];
    logic [AW-1:0]   free_len [DEPTH];
    int              free_count;
    logic [AW-1:0]   bump_ptr;
    logic [30:0]     dflt_align;

    alloc_result_t   pending_results[$];
    alloc_result_t   typed_results[$];
    bit              typed_known[$];
    logic [AW-1:0]   live_addr[$];
    logic [AW-1:0]   live_size[$];
    int              mismatches;
    int              idle_cycles;
    bit              no_gaps;
    request_row_t    dir_rows[$];

    first_fit_range_allocator_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .range_addr  (range_addr),
        .range_size  (range_size),
        .alignment   (alignment),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .result_addr (result_addr),
        .from_bump   (from_bump),
        .status      (status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Effective alignment: highest set bit; zero takes the default, and a zero default counts as one
    function automatic logic [AW:0] eff_align(input logic [30:0] a);
        logic [AW:0] p;
        p = (AW+1)'(1);
        if (a == 0)
            a = dflt_align;
        for (int b = 0; b < 31; b++)
            if (a[b])
                p = (48'd1 << b);
        return p;
    endfunction

    task automatic drop_entry(input int i);
        for (int k = i; k + 1 < free_count; k++)
        begin
            free_start[k] = free_start[k+1];
            free_len[k]   = free_len[k+1];
        end
        free_count--;
    endtask

    task automatic add_entry(input int i, input logic [AW-1:0] s, input logic [AW-1:0] l);
        for (int k = free_count; k > i; k--)
        begin
            free_start[k] = free_start[k-1];
            free_len[k]   = free_len[k-1];
        end
        free_start[i] = s;
        free_len[i]   = l;
        free_count++;
    endtask

    // Compute the result of one request and update the model
    task automatic predict_request(input logic o, input logic [AW-1:0] a,
                                   input logic [AW-1:0] sz, input logic [30:0] al,
                                   output alloc_result_t r);
        logic [AW:0] m, st, len, as_, waste, rest, ba;
        int i;
        bit merged;
        r = '{addr: '0, bump: 1'b0, st: STATUS_OK};
        if (o == OP_ALLOC)
        begin
            m = eff_align(al) - (AW+1)'(1);
            for (i = 0; i < free_count; i++)
            begin
                st    = {1'b0, free_start[i]};
                len   = {1'b0, free_len[i]};
                as_   = (st + m) & ~m;
                waste = as_ - st;
                if (len >= waste && len - waste >= {1'b0, sz})
                begin
                    r.addr = as_[AW-1:0];
                    if (waste == 0 && len == {1'b0, sz})
                        drop_entry(i);
                    else if (waste == 0)
                    begin
                        free_start[i] = free_start[i] + sz;
                        free_len[i]   = free_len[i] - sz;
                    end
                    else
                    begin
                        rest = len - waste - {1'b0, sz};
                        free_len[i] = waste[AW-1:0];
                        if (rest > 0)
                        begin
                            if (free_count < DEPTH)
                                add_entry(i + 1, as_[AW-1:0] + sz, rest[AW-1:0]);
                            else
                                r.st = STATUS_DROPPED;
                        end
                    end
                    return;
                end
            end
            ba     = ({1'b0, bump_ptr} + m) & ~m;
            r.addr = ba[AW-1:0];
            r.bump = 1'b1;
            if (ba >= ADDR_SPAN || {1'b0, sz} >= ADDR_SPAN - ba)
                r.st = STATUS_BUMP_RANGE;
            bump_ptr = ba[AW-1:0] + sz;
            return;
        end
        if (a == 0 || sz == 0 || {1'b0, sz} > ADDR_SPAN - {1'b0, a})
        begin
            r.st = STATUS_FREE_IGNORED;
            return;
        end
        i = 0;
        while (i < free_count && free_start[i] < a)
            i++;
        merged = 1'b0;
        if (i > 0 && {1'b0, free_start[i-1]} + free_len[i-1] == {1'b0, a})
        begin
            free_len[i-1] = free_len[i-1] + sz;
            merged = 1'b1;
        end
        if (i < free_count && {1'b0, a} + sz == {1'b0, free_start[i]})
        begin
            if (merged)
            begin
                free_len[i-1] = free_len[i-1] + free_len[i];
                drop_entry(i);
            end
            else
            begin
                free_start[i] = a;
                free_len[i]   = free_len[i] + sz;
            end
            return;
        end
        if (merged)
            return;
        if (free_count >= DEPTH)
        begin
            r.st = STATUS_DROPPED;
            return;
        end
        add_entry(i, a, sz);
    endtask

    task automatic report_mismatch(input string what, input logic [AW-1:0] got,
                                   input logic [AW-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Check every result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected beat", result_addr, '0);
            else
            begin
                alloc_result_t want, typed;
                bit has_typed;
                want      = pending_results.pop_front();
                typed     = typed_results.pop_front();
                has_typed = typed_known.pop_front();
                if (has_typed && typed != want)
                    report_mismatch("table row", AW'(typed), AW'(want));
                if (result_addr !== want.addr)
                    report_mismatch("result_addr", result_addr, want.addr);
                if (from_bump !== want.bump)
                    report_mismatch("from_bump", AW'(from_bump), AW'(want.bump));
                if (status !== want.st)
                    report_mismatch("status", AW'(status), AW'(want.st));
            end
        end
    end

    // Watchdog: count cycles with no accepted beat
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Issue one request and hold it until accepted; start stays high into
    // the next request while the block is busy, and drops on an idle gap
    task automatic send_request(input logic o, input logic [AW-1:0] a,
                                input logic [AW-1:0] sz, input logic [30:0] al,
                                input bit known, input alloc_result_t typed);
        alloc_result_t r;
        if (!no_gaps)
            while ($urandom_range(99) < 33)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        op         <= o;
        range_addr <= a;
        range_size <= sz;
        alignment  <= al;
        start      <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(o, a, sz, al, r);
        pending_results.push_back(r);
        typed_results.push_back(typed);
        typed_known.push_back(known);
        if (o == OP_ALLOC && r.st == STATUS_OK && sz != 0 && live_addr.size() < 400)
        begin
            live_addr.push_back(r.addr);
            live_size.push_back(sz);
        end
        @(negedge clk);
    endtask

    // Drain outstanding results, then write the default alignment
    task automatic write_default(input logic [30:0] v);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (2 * DEPTH + 10)
            @(negedge clk);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        dflt_align = v;
    endtask

    task automatic add_row(input logic o, input logic [AW-1:0] a, input logic [AW-1:0] sz,
                           input logic [30:0] al, input bit known, input alloc_result_t r);
        request_row_t row;
        row = '{op: o, addr: a, size: sz, align: al, known: known, res: r};
        dir_rows.push_back(row);
    endtask

    task automatic random_phase(input int count);
        logic [AW-1:0] a, sz;
        logic [30:0] al;
        int sel, k;
        for (int n = 0; n < count; n++)
        begin
            no_gaps = (n >= count / 2 && n < count / 2 + 60);
            sel = $urandom_range(99);
            al  = ($urandom_range(3) == 0) ? 31'd0 : (31'd1 << $urandom_range(30));
            if ($urandom_range(9) == 0)
                al = 31'($urandom);
            sz = 47'($urandom_range(1, 5000));
            if (sel < 40)
                send_request(OP_ALLOC, 47'({$urandom, $urandom}), sz, al, 1'b0, '0);
            else if (sel < 80 && live_addr.size() != 0)
            begin
                k = $urandom_range(live_addr.size() - 1);
                a = live_addr[k];
                sz = live_size[k];
                live_addr.delete(k);
                live_size.delete(k);
                send_request(OP_FREE, a, sz, al, 1'b0, '0);
            end
            else if (sel < 93)
            begin
                a = 47'h2000_0000 + 47'($urandom_range(1 << 20)) * 47'd16;
                send_request(OP_FREE, a, 47'($urandom_range(1, 512) * 16), al, 1'b0, '0);
            end
            else
            begin
                a  = 47'({$urandom, $urandom});
                sz = 47'({$urandom, $urandom});
                if ($urandom_range(1))
                    sz = sz >> $urandom_range(46);
                send_request(1'($urandom_range(1)), a, sz, al, 1'b0, '0);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        op          = OP_ALLOC;
        range_addr  = '0;
        range_size  = '0;
        alignment   = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        mismatches  = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        free_count  = 0;
        bump_ptr    = BUMP_RESET[AW-1:0];
        dflt_align  = ALIGN_RESET;
        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;

        // Directed table: expected result typed in where obvious
        add_row(OP_ALLOC, '0, 47'd16, 31'd0, 1'b1,
                '{addr: 47'h2000_0000, bump: 1'b1, st: STATUS_OK});
        add_row(OP_FREE, '0, 47'd16, 31'd0, 1'b1,
                '{addr: '0, bump: 1'b0, st: STATUS_FREE_IGNORED});
        add_row(OP_FREE, 47'h1000, '0, 31'd0, 1'b1,
                '{addr: '0, bump: 1'b0, st: STATUS_FREE_IGNORED});
        add_row(OP_FREE, '1, 47'd2, 31'd0, 1'b1,
                '{addr: '0, bump: 1'b0, st: STATUS_FREE_IGNORED});
        add_row(OP_FREE, '1, 47'd1, 31'd0, 1'b0, '0);
        add_row(OP_FREE, 47'h1000, 47'h1000, 31'd0, 1'b0, '0);
        add_row(OP_FREE, 47'h3000, 47'h1000, 31'd0, 1'b0, '0);
        add_row(OP_FREE, 47'h2000, 47'h1000, 31'd0, 1'b0, '0);
        add_row(OP_ALLOC, '1, 47'h1000, 31'h4000_0000, 1'b0, '0);
        add_row(OP_ALLOC, '0, 47'h1000, 31'd4096, 1'b0, '0);
        add_row(OP_ALLOC, '0, 47'h100, 31'd1, 1'b0, '0);
        add_row(OP_ALLOC, '0, 47'h10, 31'h0000_0300, 1'b0, '0);
        add_row(OP_ALLOC, '0, '0, 31'h7FFF_FFFF, 1'b0, '0);
        add_row(OP_ALLOC, '0, 47'h1F00, 31'd0, 1'b0, '0);
        add_row(OP_FREE, 47'h1_0000, 47'h100, 31'd0, 1'b0, '0);
        add_row(OP_FREE, 47'h1_0100, 47'h100, 31'd0, 1'b0, '0);
        add_row(OP_FREE, 47'h0_FF00, 47'h100, 31'd0, 1'b0, '0);
        add_row(OP_ALLOC, '0, 47'h300, 31'd0, 1'b0, '0);
        add_row(OP_ALLOC, '0, '1, 31'd1, 1'b0, '0);
        add_row(OP_ALLOC, '0, 47'd8, 31'd8, 1'b0, '0);
        foreach (dir_rows[n])
            send_request(dir_rows[n].op, dir_rows[n].addr, dir_rows[n].size,
                         dir_rows[n].align, dir_rows[n].known, dir_rows[n].res);

        // Fill the table with isolated ranges, then hit full-table cases
        for (int n = 0; n < DEPTH + 2; n++)
            send_request(OP_FREE, 47'h4000_0000 + 47'(n) * 47'h100, 47'h40, 31'd0,
                         1'b0, '0);
        send_request(OP_ALLOC, '0, 47'h10, 31'd16, 1'b0, '0);
        send_request(OP_ALLOC, '0, 47'h10, 31'd32, 1'b0, '0);

        random_phase(250);
        write_default(31'd1);
        random_phase(250);
        write_default(31'd0);
        random_phase(150);
        write_default(31'h4000_0000);
        random_phase(100);
        write_default(31'h7FFF_FFFF);
        random_phase(100);
        write_default(31'd64);
        random_phase(150);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (2 * DEPTH + 10)
            @(negedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
rtl/core/ffra_pkg.sv
rtl/core/ffra_ram.sv
rtl/core/ffra_ctrl.sv
rtl/core/ffra_dp.sv
rtl/core/first_fit_range_allocator_top.sv
verif/first_fit_range_allocator_top_tb.sv
